// ===== src/tplc_pkg.sv =====
`timescale 1ns / 1ps

package tplc_pkg;

	// Clock period used for the PHY delay wrap correction, in picoseconds.
	localparam logic [13:0] PERIOD_PS = 14'd8000;

	// Item kinds.
	localparam logic [2:0] KIND_TICK       = 3'd0;
	localparam logic [2:0] KIND_START_LOCK = 3'd1;
	localparam logic [2:0] KIND_IDLE_CHECK = 3'd2;
	localparam logic [2:0] KIND_TX_PATTERN = 3'd3;
	localparam logic [2:0] KIND_TX_MEASURE = 3'd4;
	localparam logic [2:0] KIND_RX_MEASURE = 3'd5;

	// Response codes.
	localparam logic [1:0] RESP_OK   = 2'd0;
	localparam logic [1:0] RESP_BUSY = 2'd1;
	localparam logic [1:0] RESP_ERR  = 2'd2;

	// Calibration actions.
	localparam logic [2:0] ACT_NONE        = 3'd0;
	localparam logic [2:0] ACT_PATTERN_ON  = 3'd1;
	localparam logic [2:0] ACT_PATTERN_OFF = 3'd2;
	localparam logic [2:0] ACT_TX_FB_ON    = 3'd3;
	localparam logic [2:0] ACT_TX_FB_OFF   = 3'd4;
	localparam logic [2:0] ACT_RX_FB_ON    = 3'd5;
	localparam logic [2:0] ACT_RX_FB_OFF   = 3'd6;

	// Configuration register indexes.
	localparam logic [2:0] REG_TX_BIAS     = 3'd0;
	localparam logic [2:0] REG_TX_RANGE    = 3'd1;
	localparam logic [2:0] REG_RX_BIAS     = 3'd2;
	localparam logic [2:0] REG_RX_RANGE    = 3'd3;
	localparam logic [2:0] REG_TX_FIXED    = 3'd4;
	localparam logic [2:0] REG_RX_FIXED    = 3'd5;
	localparam logic [2:0] REG_IS_DOWNLINK = 3'd6;

	typedef enum logic [1:0] {
		ST_DOWN    = 2'd0,
		ST_UP      = 2'd1,
		ST_CAL     = 2'd2,
		ST_LOCKING = 2'd3
	} port_state_t;

	typedef enum logic [2:0] {
		LK_NONE   = 3'd0,
		LK_WAIT_H = 3'd1,
		LK_WAIT_D = 3'd2,
		LK_LOCKED = 3'd3,
		LK_START  = 3'd4
	} lock_state_t;

	typedef struct packed {
		logic [12:0] tx_bias;
		logic [12:0] tx_span;
		logic [12:0] rx_bias;
		logic [12:0] rx_span;
		logic [31:0] tx_fixed;
		logic [31:0] rx_fixed;
		logic        is_downlink;
	} cfg_t;

	localparam cfg_t CFG_RST = '{
		tx_bias:     13'd7800,
		tx_span:     13'd5600,
		rx_bias:     13'd7800,
		rx_span:     13'd5600,
		tx_fixed:    32'd0,
		rx_fixed:    32'd0,
		is_downlink: 1'b0
	};

	// Flag part of one input beat; the phase readings travel separately.
	typedef struct packed {
		logic [2:0] kind;
		logic       on_off;
		logic       link_up;
		logic       hpll_locked;
		logic       dmpll_locked;
		logic       dmtd_valid;
		logic       meas_valid;
		logic       others_calibrating;
	} item_t;

	// One result beat, less the phase value and the fixed delays.
	typedef struct packed {
		logic [1:0]  response;
		port_state_t port_state;
		logic        seq_locked;
		logic        phase_valid;
		logic        tx_cal_ok;
		logic        rx_cal_ok;
		logic [31:0] tx_phy_delay;
		logic [31:0] rx_phy_delay;
		logic        hpll_switch;
		logic        dmpll_switch;
		logic [2:0]  cal_action;
	} result_t;

endpackage

// ===== src/tplc_corr.sv =====
`timescale 1ns / 1ps

module tplc_corr (
	input  logic [31:0] raw,
	input  logic [12:0] bias,
	input  logic [12:0] span,
	output logic [31:0] delay
);
	import tplc_pkg::*;

	logic [13:0]        sum;
	logic               wrap_en;
	logic signed [14:0] low_raw;
	logic signed [14:0] low;
	logic signed [31:0] d;
	logic signed [31:0] b;
	logic signed [31:0] low_ext;
	logic               keep;
	logic [31:0]        sub;
	logic [31:0]        alt;

	always_comb begin
		sum     = {1'b0, bias} + {1'b0, span};
		wrap_en = sum > PERIOD_PS;
		low_raw = $signed({2'b00, bias}) - $signed({2'b00, span});
		low     = (low_raw < 0) ? low_raw + $signed({1'b0, PERIOD_PS}) : low_raw;
		d       = $signed(raw);
		b       = $signed({19'd0, bias});
		low_ext = {{17{low[14]}}, low};
		// The measurement counts as already past the bias when it lies above
		// it, or inside the window between the wrapped low edge and the bias.
		keep    = (d > b) || ((d < b) && (d > low_ext));
		sub     = raw - {19'd0, bias};
		alt     = sub + {18'd0, PERIOD_PS};
		delay   = (wrap_en && !keep) ? alt : sub;
	end

endmodule

// ===== src/tplc_ctrl.sv =====
`timescale 1ns / 1ps

module tplc_ctrl #(
	parameter int PHASE_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    step,
	input  tplc_pkg::item_t         item,
	input  logic [PHASE_BITS-1:0]   dmtd_phase,
	input  logic [PHASE_BITS-1:0]   meas_phase,
	input  tplc_pkg::cfg_t          cfg,
	output tplc_pkg::result_t       res,
	output logic [PHASE_BITS-1:0]   res_phase
);
	import tplc_pkg::*;

	port_state_t           port_q, port_d;
	lock_state_t           lock_q, lock_d;
	logic                  locked_q, locked_d;
	logic                  tx_done_q, tx_done_d;
	logic                  rx_done_q, rx_done_d;
	logic                  tx_wait_q, tx_wait_d;
	logic                  rx_wait_q, rx_wait_d;
	logic [PHASE_BITS-1:0] phase_q, phase_d;
	logic                  pval_q, pval_d;
	logic [31:0]           tx_phy_q, tx_phy_d;
	logic [31:0]           rx_phy_q, rx_phy_d;

	logic [31:0] tx_raw, rx_raw, tx_corr, rx_corr;
	logic [1:0]  resp;
	logic        hsw, dsw;
	logic [2:0]  act;

	assign tx_raw = 32'(meas_phase);
	assign rx_raw = {18'd0, PERIOD_PS} - 32'(meas_phase);

	tplc_corr u_tx_corr (
		.raw   (tx_raw),
		.bias  (cfg.tx_bias),
		.span  (cfg.tx_span),
		.delay (tx_corr)
	);

	tplc_corr u_rx_corr (
		.raw   (rx_raw),
		.bias  (cfg.rx_bias),
		.span  (cfg.rx_span),
		.delay (rx_corr)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			port_q    <= ST_DOWN;
			lock_q    <= LK_NONE;
			locked_q  <= 1'b0;
			tx_done_q <= 1'b0;
			rx_done_q <= 1'b0;
			tx_wait_q <= 1'b0;
			rx_wait_q <= 1'b0;
			phase_q   <= '0;
			pval_q    <= 1'b0;
			tx_phy_q  <= '0;
			rx_phy_q  <= '0;
		end else if (step) begin
			port_q    <= port_d;
			lock_q    <= lock_d;
			locked_q  <= locked_d;
			tx_done_q <= tx_done_d;
			rx_done_q <= rx_done_d;
			tx_wait_q <= tx_wait_d;
			rx_wait_q <= rx_wait_d;
			phase_q   <= phase_d;
			pval_q    <= pval_d;
			tx_phy_q  <= tx_phy_d;
			rx_phy_q  <= rx_phy_d;
		end
	end

	always_comb begin
		port_d    = port_q;
		lock_d    = lock_q;
		locked_d  = locked_q;
		tx_done_d = tx_done_q;
		rx_done_d = rx_done_q;
		tx_wait_d = tx_wait_q;
		rx_wait_d = rx_wait_q;
		phase_d   = phase_q;
		pval_d    = pval_q;
		tx_phy_d  = tx_phy_q;
		rx_phy_d  = rx_phy_q;
		resp      = RESP_OK;
		hsw       = 1'b0;
		dsw       = 1'b0;
		act       = ACT_NONE;

		unique case (item.kind)
			KIND_TICK: begin
				if (!item.link_up && port_q != ST_DOWN) begin
					// Link loss clears the port, yet sets the TX done flag.
					port_d    = ST_DOWN;
					lock_d    = LK_NONE;
					locked_d  = 1'b0;
					rx_done_d = 1'b0;
					tx_done_d = 1'b1;
					tx_wait_d = 1'b0;
					rx_wait_d = 1'b0;
				end else begin
					unique case (lock_q)
						LK_START: begin
							hsw    = 1'b1;
							lock_d = LK_WAIT_H;
						end
						LK_WAIT_H: begin
							if (item.hpll_locked) begin
								dsw    = 1'b1;
								lock_d = LK_WAIT_D;
							end
						end
						LK_WAIT_D: begin
							if (!item.hpll_locked) begin
								lock_d = LK_NONE;
							end else if (item.dmpll_locked) begin
								lock_d = LK_LOCKED;
							end
						end
						LK_LOCKED: begin
							if (!item.hpll_locked || !item.dmpll_locked) begin
								lock_d = LK_NONE;
							end
							locked_d = 1'b1;
						end
						default: begin
						end
					endcase

					unique case (port_q)
						ST_DOWN: begin
							if (item.link_up) begin
								port_d = ST_UP;
							end
						end
						ST_UP: begin
							if (item.dmtd_valid) begin
								phase_d = dmtd_phase;
								pval_d  = 1'b1;
							end else begin
								pval_d  = 1'b0;
							end
						end
						ST_LOCKING: begin
							if (locked_d) begin
								port_d = ST_UP;
							end
						end
						default: begin
							if (cfg.is_downlink) begin
								tx_done_d = 1'b1;
								rx_done_d = 1'b1;
								tx_phy_d  = '0;
								rx_phy_d  = '0;
								tx_wait_d = 1'b0;
								rx_wait_d = 1'b0;
							end else if ((tx_wait_q || rx_wait_q) && item.meas_valid) begin
								// TX is served first when both paths wait.
								if (tx_wait_q) begin
									tx_done_d = 1'b1;
									tx_phy_d  = tx_corr;
									tx_wait_d = 1'b0;
								end else begin
									rx_done_d = 1'b1;
									rx_phy_d  = rx_corr;
									rx_wait_d = 1'b0;
								end
							end
						end
					endcase
				end
			end
			KIND_START_LOCK: begin
				if (port_q != ST_UP) begin
					resp = RESP_BUSY;
				end else begin
					port_d = ST_LOCKING;
					lock_d = LK_START;
				end
			end
			KIND_IDLE_CHECK: begin
				resp = (!item.others_calibrating && port_q == ST_UP) ? RESP_OK : RESP_BUSY;
			end
			KIND_TX_PATTERN: begin
				port_d = item.on_off ? ST_CAL : ST_UP;
				act    = item.on_off ? ACT_PATTERN_ON : ACT_PATTERN_OFF;
			end
			KIND_TX_MEASURE: begin
				if (item.on_off) begin
					if (port_q == ST_CAL) begin
						tx_wait_d = 1'b1;
						act       = ACT_TX_FB_ON;
					end else begin
						resp      = RESP_ERR;
					end
				end else begin
					act = ACT_TX_FB_OFF;
				end
			end
			KIND_RX_MEASURE: begin
				if (item.on_off) begin
					rx_wait_d = 1'b1;
					act       = ACT_RX_FB_ON;
					port_d    = ST_CAL;
				end else begin
					act       = ACT_RX_FB_OFF;
					port_d    = ST_UP;
				end
			end
			default: begin
				resp = RESP_ERR;
			end
		endcase

		res.response     = resp;
		res.port_state   = port_d;
		res.seq_locked   = (lock_d == LK_LOCKED);
		res.phase_valid  = pval_d;
		res.tx_cal_ok    = tx_done_d;
		res.rx_cal_ok    = rx_done_d;
		res.tx_phy_delay = tx_phy_d;
		res.rx_phy_delay = rx_phy_d;
		res.hpll_switch  = hsw;
		res.dmpll_switch = dsw;
		res.cal_action   = act;
		res_phase        = phase_d;
	end

endmodule

// ===== src/timing_port_lock_calibration_fsm.sv =====
`timescale 1ns / 1ps

// Port controller for one timing-switch port. Every input beat is either a
// status tick (link, PLL lock, DMTD phase and calibration measurement) or a
// command (start lock, calibration idle check, TX pattern, TX measure, RX
// measure), and each beat produces exactly one result beat carrying the
// response code, the port state, the lock and calibration flags, the stored
// DMTD phase, the TX and RX delays (PHY delay plus fixed delay, modulo 2^32),
// the PLL switch pulses and the calibration action. A beat is registered on
// entry in the input stage, goes through the state update and lands in the
// output register, and one beat can be taken in every cycle while the output
// side keeps up. The output register decouples the two sides: a new input
// beat is taken while a finished result still waits, and input stall rises
// only when both the input stage and the output register are full and the
// output is stalled. Measured PHY delays are corrected around the 8000 ps
// period with the bias and range registers; downlink ports skip calibration
// and report zero PHY delay. The configuration port is always ready;
// registers are to be written only while no beat is in flight.

module timing_port_lock_calibration_fsm #(
	parameter int PHASE_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,

	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [2:0]            cfg_index,
	input  logic [31:0]           cfg_data,

	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [2:0]            kind,
	input  logic                  on_off,
	input  logic                  link_up,
	input  logic                  hpll_locked,
	input  logic                  dmpll_locked,
	input  logic                  dmtd_valid,
	input  logic [PHASE_BITS-1:0] dmtd_phase,
	input  logic                  meas_valid,
	input  logic [PHASE_BITS-1:0] meas_phase,
	input  logic                  others_calibrating,

	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [1:0]            response,
	output logic [1:0]            port_state,
	output logic                  seq_locked,
	output logic [PHASE_BITS-1:0] phase_value,
	output logic                  phase_valid,
	output logic                  tx_cal_ok,
	output logic                  rx_cal_ok,
	output logic [31:0]           tx_delay,
	output logic [31:0]           rx_delay,
	output logic                  hpll_switch,
	output logic                  dmpll_switch,
	output logic [2:0]            cal_action
);
	import tplc_pkg::*;

	cfg_t                  cfg_q;

	logic                  valid_s1;
	item_t                 item_s1;
	logic [PHASE_BITS-1:0] dmtd_s1;
	logic [PHASE_BITS-1:0] meas_s1;

	logic                  valid_s2;
	result_t               res_s2;
	logic [PHASE_BITS-1:0] phase_s2;

	logic                  accept;
	logic                  advance;
	item_t                 item_in;
	result_t               res;
	logic [PHASE_BITS-1:0] res_phase;

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_TX_BIAS:     cfg_q.tx_bias     <= cfg_data[12:0];
				REG_TX_RANGE:    cfg_q.tx_span     <= cfg_data[12:0];
				REG_RX_BIAS:     cfg_q.rx_bias     <= cfg_data[12:0];
				REG_RX_RANGE:    cfg_q.rx_span     <= cfg_data[12:0];
				REG_TX_FIXED:    cfg_q.tx_fixed    <= cfg_data;
				REG_RX_FIXED:    cfg_q.rx_fixed    <= cfg_data;
				REG_IS_DOWNLINK: cfg_q.is_downlink <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// The input stage moves on when the output register is empty or is being
	// emptied in this cycle.
	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign accept   = in_valid && !in_stall;

	assign item_in = '{
		kind:               kind,
		on_off:             on_off,
		link_up:            link_up,
		hpll_locked:        hpll_locked,
		dmpll_locked:       dmpll_locked,
		dmtd_valid:         dmtd_valid,
		meas_valid:         meas_valid,
		others_calibrating: others_calibrating
	};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_in;
			dmtd_s1 <= dmtd_phase;
			meas_s1 <= meas_phase;
		end
	end

	// Port state, lock sequencer and calibration update.
	tplc_ctrl #(
		.PHASE_BITS (PHASE_BITS)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.item       (item_s1),
		.dmtd_phase (dmtd_s1),
		.meas_phase (meas_s1),
		.cfg        (cfg_q),
		.res        (res),
		.res_phase  (res_phase)
	);

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= advance || (valid_s2 && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2   <= res;
			phase_s2 <= res_phase;
		end
	end

	assign out_valid    = valid_s2;
	assign response     = res_s2.response;
	assign port_state   = res_s2.port_state;
	assign seq_locked   = res_s2.seq_locked;
	assign phase_value  = phase_s2;
	assign phase_valid  = res_s2.phase_valid;
	assign tx_cal_ok    = res_s2.tx_cal_ok;
	assign rx_cal_ok    = res_s2.rx_cal_ok;
	// The user must keep the fixed delays still while beats are in flight; the block
	// does not enforce it. The sum is therefore formed after the output register.
	assign tx_delay     = res_s2.tx_phy_delay + cfg_q.tx_fixed;
	assign rx_delay     = res_s2.rx_phy_delay + cfg_q.rx_fixed;
	assign hpll_switch  = res_s2.hpll_switch;
	assign dmpll_switch = res_s2.dmpll_switch;
	assign cal_action   = res_s2.cal_action;

endmodule
